FILE: hdl/line_pair_selector_unit_macros.svh
// Assertion macros for the line pair selector.
// No dependencies.
`ifndef LINE_PAIR_SELECTOR_UNIT_MACROS_SVH
`define LINE_PAIR_SELECTOR_UNIT_MACROS_SVH
`define LPS_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lps check failed");
`define LPS_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lps check failed");
`endif

FILE: hdl/lps_pkg.sv
// Types and constants of the line pair selector.
// No dependencies.
package lps_pkg;
  localparam int SLOPE_W = 16;
  localparam int OFS_W   = 16;
  localparam int ERR_W   = 16;
  localparam int BRI_W   = 32;
  localparam int IDX_W   = 6;
  localparam int CONF_W  = 16;
  localparam logic [1:0] REG_ANGLE   = 2'd0;
  localparam logic [1:0] REG_ERROR   = 2'd1;
  localparam logic [1:0] REG_GAP_MAX = 2'd2;
  localparam logic [1:0] REG_GAP_MIN = 2'd3;

  typedef struct packed {
    logic [14:0] max_angle;
    logic [15:0] max_err;
    logic [11:0] max_gap;
    logic [11:0] min_gap;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic [47:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [16:0] quo;
  } div_rsp_t;
endpackage

FILE: hdl/lps_divider.sv
// Restoring divider, one quotient bit per cycle while busy, keeping the low 17 quotient bits.
// Depends on lps_pkg.
module lps_divider import lps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [48:0] rem_r, rem_nxt;
  logic [47:0] num_r, num_nxt;
  logic [31:0] den_r, den_nxt;
  logic [16:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [48:0] sh;

  // quotient < 2^16 guaranteed by num < den before the shift; 48 steps
  always_comb begin
    rem_nxt = rem_r; num_nxt = num_r; den_nxt = den_r; quo_nxt = quo_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {rem_r[47:0], num_r[47]};
    if (req.start) begin
      rem_nxt = '0; num_nxt = req.num; den_nxt = req.den; quo_nxt = '0;
      cnt_nxt = 6'd48; busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[46:0], 1'b0};
      if (sh >= {17'd0, den_r}) begin
        rem_nxt = sh - {17'd0, den_r};
        quo_nxt = {quo_r[15:0], 1'b1};
      end else begin
        rem_nxt = sh;
        quo_nxt = {quo_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt; num_r <= num_nxt; den_r <= den_nxt; quo_r <= quo_nxt;
    if (!rst_n) begin
      cnt_r <= '0; busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

FILE: hdl/lps_pair_test.sv
// Pair test datapath: two register stages, the limit tests then the
// cross-multiplied angle-confidence test. Depends on lps_pkg.
module lps_pair_test import lps_pkg::*; (
  input  logic        clk,
  input  cfg_t        cfg,
  input  logic [47:0] geo_a,
  input  logic [47:0] geo_b,
  output logic        pass_r,
  output logic        a_upper_r,
  output logic [47:0] num_r,
  output logic [31:0] den_r
);
  logic signed [16:0] ds, os;
  logic [16:0] d, g, e;
  logic        pre;
  logic [47:0] num_s;
  logic [31:0] den_s;
  logic        pre_r, up_r;
  logic [16:0] d_r, rem_r;

  always_comb begin
    ds = $signed({geo_b[47], geo_b[47:32]}) - $signed({geo_a[47], geo_a[47:32]});
    os = $signed({geo_b[31], geo_b[31:16]}) - $signed({geo_a[31], geo_a[31:16]});
    d  = ds[16] ? 17'(-ds) : 17'(ds);
    g  = os[16] ? 17'(-os) : 17'(os);
    e  = {1'b0, geo_a[15:0]} + {1'b0, geo_b[15:0]};
    pre = (d < {2'b0, cfg.max_angle}) && (e < {1'b0, cfg.max_err})
       && (g < {1'b0, cfg.max_gap, 4'd0}) && (g > {1'b0, cfg.min_gap, 4'd0});
  end

  always_ff @(posedge clk) begin
    pre_r <= pre;
    up_r  <= os[16];
    d_r   <= d;
    rem_r <= {1'b0, cfg.max_err} - e;
  end

  always_comb begin
    num_s = {14'd0, 34'(d_r) * 34'({1'b0, cfg.max_err})};
    den_s = 32'({2'b0, cfg.max_angle}) * 32'(rem_r);
  end

  always_ff @(posedge clk) begin
    pass_r    <= pre_r && (num_s < {16'd0, den_s});
    a_upper_r <= up_r;
    num_r     <= num_s;
    den_r     <= den_s;
  end
endmodule

FILE: hdl/line_pair_selector_unit.sv
// Line pair selector: a line store in memory and a sequenced pair scan
// sharing one pair test unit and one serial divider.
// Depends on lps_pkg, lps_pair_test, lps_divider and the macro header.
//
// Use: lines enter as in_ words, one per cycle while collecting. A word
// with in_tlast starts the pair scan; in_tready stays low until the out_
// word of that frame is taken.
// Scan: a pair goes through a memory read, two test stages and a compare,
// with an extra read state when the first line of the pair changes; each
// new best pair also waits for the shared divider. A frame of fewer than
// two lines gives its out_ word the cycle after its last line.
// One out_ word per frame, held until out_tready; a new frame is not taken
// while it waits. Configuration writes on cfg_ are always accepted.
// Reset clears the line count, the overflow flag and all control state;
// the line store needs no clearing.
`include "line_pair_selector_unit_macros.svh"
module line_pair_selector_unit import lps_pkg::*; #(
  parameter int MAX_LINES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // line_slope, line_offset, fit_error, brightness
  input  logic        in_tlast,  // last_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // pair_found, upper_index, lower_index,
                                 // pair_brightness, confidence, lines_dropped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam logic [2:0] S_LOAD = 3'd0, S_RDA = 3'd1, S_RDB = 3'd2,
    S_T1 = 3'd3, S_T2 = 3'd4, S_CMP = 3'd5, S_DIV = 3'd6, S_OUT = 3'd7;

  cfg_t cfg_r;
  logic [2:0]   st_r;
  logic [CW-1:0] cnt_r;
  logic         ovf_r;
  logic [AW-1:0] a_r, b_r;
  logic [47:0]  geo_mem [MAX_LINES];
  logic [31:0]  bri_mem [MAX_LINES];
  logic [47:0]  rd_geo, geo_a_r;
  logic [31:0]  rd_bri, bri_a_r;
  logic         found_r, best_up_r;
  logic [AW-1:0] best_i_r, best_j_r;
  logic [32:0]  best_sum_r, sum;
  logic [15:0]  conf_r;
  logic         pass, a_up;
  logic [47:0]  num;
  logic [31:0]  den;
  logic         accept, wr;
  div_req_t     dreq;
  div_rsp_t     drsp;

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == S_LOAD);
  assign accept = in_tvalid && in_tready;
  assign wr = accept && (cnt_r < CW'(MAX_LINES));

  always_ff @(posedge clk) begin
    if (wr) begin
      geo_mem[cnt_r[AW-1:0]] <= {in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]};
      bri_mem[cnt_r[AW-1:0]] <= in_tdata[79:48];
    end
    rd_geo <= geo_mem[(st_r == S_RDA) ? a_r : b_r];
    rd_bri <= bri_mem[(st_r == S_RDA) ? a_r : b_r];
  end

  lps_pair_test u_test (.clk, .cfg(cfg_r), .geo_a(geo_a_r), .geo_b(rd_geo),
    .pass_r(pass), .a_upper_r(a_up), .num_r(num), .den_r(den));

  assign sum = {1'b0, bri_a_r} + {1'b0, rd_bri};
  assign dreq.start = (st_r == S_CMP) && pass && (!found_r || sum > best_sum_r);
  assign dreq.num = {num[31:0], 16'd0};
  assign dreq.den = den;

  lps_divider u_div (.clk, .rst_n, .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0; st_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0;
      found_r <= 1'b0; a_r <= '0; b_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ANGLE:   cfg_r.max_angle <= cfg_data[14:0];
          REG_ERROR:   cfg_r.max_err   <= cfg_data;
          REG_GAP_MAX: cfg_r.max_gap   <= cfg_data[11:0];
          REG_GAP_MIN: cfg_r.min_gap   <= cfg_data[11:0];
          default: ;
        endcase
      end
      case (st_r)
        S_LOAD: if (accept) begin
          if (wr) cnt_r <= cnt_r + CW'(1); else ovf_r <= 1'b1;
          found_r <= 1'b0; a_r <= '0; b_r <= AW'(1);
          if (in_tlast) begin
            if ({1'b0, cnt_r} + (CW+1)'(wr) < (CW+1)'(2)) st_r <= S_OUT;
            else st_r <= S_RDA;
          end
        end
        S_RDA: st_r <= S_RDB;
        S_RDB: begin
          // first line is only fetched when a pair row starts
          if (b_r == a_r + AW'(1)) begin
            geo_a_r <= rd_geo; bri_a_r <= rd_bri;
          end
          st_r <= S_T1;
        end
        S_T1: st_r <= S_T2;
        S_T2: st_r <= S_CMP;
        S_CMP: begin
          if (dreq.start) begin
            found_r <= 1'b1; best_sum_r <= sum;
            best_i_r <= a_r; best_j_r <= b_r; best_up_r <= a_up;
            st_r <= S_DIV;
          end else st_r <= S_RDB;
          if (CW'(b_r) + CW'(1) < cnt_r) b_r <= b_r + AW'(1);
          else if (CW'(a_r) + CW'(2) < cnt_r) begin
            a_r <= a_r + AW'(1); b_r <= a_r + AW'(2);
            if (!dreq.start) st_r <= S_RDA;
          end else if (!dreq.start) st_r <= S_OUT;
        end
        S_DIV: if (drsp.done) begin
          conf_r <= drsp.quo[16] ? 16'hFFFF : drsp.quo[15:0];
          if (b_r == best_j_r && a_r == best_i_r) st_r <= S_OUT;
          else st_r <= (b_r == a_r + AW'(1)) ? S_RDA : S_RDB;
        end
        S_OUT: if (out_tready) begin
          st_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0;
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  assign out_tvalid = (st_r == S_OUT);
  always_comb begin
    out_tdata = '0;
    out_tdata[0] = found_r;
    if (found_r) begin
      out_tdata[6:1]   = best_up_r ? 6'(best_i_r) : 6'(best_j_r);
      out_tdata[12:7]  = best_up_r ? 6'(best_j_r) : 6'(best_i_r);
      out_tdata[45:13] = best_sum_r;
      out_tdata[61:46] = conf_r;
    end
    out_tdata[62] = ovf_r;
  end

  `LPS_ASSERT_IMP(a_ready_load, in_tready, st_r == S_LOAD)
  `LPS_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_r <= CW'(MAX_LINES))
  `LPS_ASSERT_NXT(a_div_start, dreq.start, st_r == S_DIV)
  `LPS_ASSERT_IMP(a_pair_order, st_r == S_CMP, a_r < b_r)
endmodule
